// File: rtl/circ_pkg.sv
// Shared constants and types for the circumcircle pipeline.
// No dependencies; used by circ_sqrt, the top level and the testbench.
`timescale 1ns / 1ps

package circ_pkg;

    // default geometry of the datapath
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // fixed field widths
    localparam int TOL_W = 16;
    localparam int OUT_W = 32;
    localparam int RAD_W = 32;
    localparam int SQ_W  = 64;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POINT     = 2'd1,
        ST_COLLINEAR = 2'd2,
        ST_SAT       = 2'd3
    } status_t;

endpackage

// File: rtl/circ_div.sv
// Pipelined restoring divider: two numerator magnitudes over one shared divisor.
// One quotient bit per stage; does not use circ_pkg.
`timescale 1ns / 1ps

module circ_div #(
    parameter int QW    = 62,
    parameter int DM    = 36,
    parameter int TAG_W = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_v,
    input  logic [QW-1:0]    num_x,
    input  logic [QW-1:0]    num_y,
    input  logic [DM-1:0]    den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_v,
    output logic [QW-1:0]    quo_x,
    output logic [QW-1:0]    quo_y,
    output logic [TAG_W-1:0] tag_out
);

    // stage taps; index 0 is the input side
    logic             v_s    [0:QW];
    logic [DM-1:0]    remx_s [0:QW];
    logic [DM-1:0]    remy_s [0:QW];
    logic [QW-1:0]    nx_s   [0:QW];
    logic [QW-1:0]    ny_s   [0:QW];
    logic [DM-1:0]    den_s  [0:QW];
    logic [TAG_W-1:0] tag_s  [0:QW];

    assign v_s[0]    = in_v;
    assign remx_s[0] = '0;
    assign remy_s[0] = '0;
    assign nx_s[0]   = num_x;
    assign ny_s[0]   = num_y;
    assign den_s[0]  = den;
    assign tag_s[0]  = tag_in;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             v_reg;
        logic [DM-1:0]    remx_reg, remy_reg, remx_next, remy_next;
        logic [QW-1:0]    nx_reg, ny_reg, nx_next, ny_next;
        logic [DM-1:0]    den_reg;
        logic [TAG_W-1:0] tag_reg;
        logic [DM:0]      shx, shy;
        logic [DM+1:0]    dfx, dfy;

        // shift in the next numerator bit, trial subtract
        always_comb
        begin
            shx = {remx_s[k], nx_s[k][QW-1]};
            shy = {remy_s[k], ny_s[k][QW-1]};
            dfx = {1'b0, shx} - {2'b00, den_s[k]};
            dfy = {1'b0, shy} - {2'b00, den_s[k]};
            remx_next = dfx[DM+1] ? shx[DM-1:0] : dfx[DM-1:0];
            remy_next = dfy[DM+1] ? shy[DM-1:0] : dfy[DM-1:0];
            nx_next   = {nx_s[k][QW-2:0], ~dfx[DM+1]};
            ny_next   = {ny_s[k][QW-2:0], ~dfy[DM+1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= v_s[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                remx_reg <= remx_next;
                remy_reg <= remy_next;
                nx_reg   <= nx_next;
                ny_reg   <= ny_next;
                den_reg  <= den_s[k];
                tag_reg  <= tag_s[k];
            end
        end

        assign v_s[k+1]    = v_reg;
        assign remx_s[k+1] = remx_reg;
        assign remy_s[k+1] = remy_reg;
        assign nx_s[k+1]   = nx_reg;
        assign ny_s[k+1]   = ny_reg;
        assign den_s[k+1]  = den_reg;
        assign tag_s[k+1]  = tag_reg;
    end

    assign out_v   = v_s[QW];
    assign quo_x   = nx_s[QW];
    assign quo_y   = ny_s[QW];
    assign tag_out = tag_s[QW];

endmodule

// File: rtl/circ_sqrt.sv
// Pipelined integer square root, 64-bit operand to 32-bit floor root.
// One result bit per stage; uses circ_pkg widths.
`timescale 1ns / 1ps

module circ_sqrt #(
    parameter int TAG_W = 68
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_v,
    input  logic [circ_pkg::SQ_W-1:0] operand,
    input  logic [TAG_W-1:0]          tag_in,
    output logic                      out_v,
    output logic [circ_pkg::RAD_W-1:0] root,
    output logic [TAG_W-1:0]          tag_out
);

    localparam int SQ_W  = circ_pkg::SQ_W;
    localparam int RAD_W = circ_pkg::RAD_W;

    logic             v_s   [0:RAD_W];
    logic [SQ_W-1:0]  x_s   [0:RAD_W];
    logic [SQ_W-1:0]  res_s [0:RAD_W];
    logic [TAG_W-1:0] tag_s [0:RAD_W];

    assign v_s[0]   = in_v;
    assign x_s[0]   = operand;
    assign res_s[0] = '0;
    assign tag_s[0] = tag_in;

    for (genvar k = 0; k < RAD_W; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (RAD_W - 1 - k));
        logic             v_reg;
        logic [SQ_W-1:0]  x_reg, res_reg, x_next, res_next, trial;

        // try the next root bit
        always_comb
        begin
            trial = res_s[k] + BIT;
            if (x_s[k] >= trial)
            begin
                x_next   = x_s[k] - trial;
                res_next = (res_s[k] >> 1) + BIT;
            end
            else
            begin
                x_next   = x_s[k];
                res_next = res_s[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (adv)
                v_reg <= v_s[k];
        end

        logic [TAG_W-1:0] tag_reg;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg   <= x_next;
                res_reg <= res_next;
                tag_reg <= tag_s[k];
            end
        end

        assign v_s[k+1]   = v_reg;
        assign x_s[k+1]   = x_reg;
        assign res_s[k+1] = res_reg;
        assign tag_s[k+1] = tag_reg;
    end

    assign out_v   = v_s[RAD_W];
    assign root    = res_s[RAD_W][RAD_W-1:0];
    assign tag_out = tag_s[RAD_W];

endmodule

// File: rtl/circumcircle_from_three_points.sv
// Circumcircle center and radius of three points, fully pipelined.
// Pipeline order: front stages, the one-bit-per-stage divider, back stages, then
// the one-bit-per-stage square root and the output register.
// Throughput: one word per cycle; in_stall rises only when the output skid word is full.
// Reset: rst_n clears all valid bits and sets tol_reg, the collinear tolerance, to 0.
// Depends on circ_pkg, circ_div, circ_sqrt.
`timescale 1ns / 1ps

module circumcircle_from_three_points #(
    parameter int COORD_WIDTH   = circ_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = circ_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [circ_pkg::TOL_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_a_x,
    input  logic signed [COORD_WIDTH-1:0] point_a_y,
    input  logic signed [COORD_WIDTH-1:0] point_b_x,
    input  logic signed [COORD_WIDTH-1:0] point_b_y,
    input  logic signed [COORD_WIDTH-1:0] point_c_x,
    input  logic signed [COORD_WIDTH-1:0] point_c_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [circ_pkg::OUT_W-1:0] center_x,
    output logic signed [circ_pkg::OUT_W-1:0] center_y,
    output logic [circ_pkg::RAD_W-1:0]    radius,
    output logic [1:0]                    status
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRACTION_BITS;
    localparam int OUT_W = circ_pkg::OUT_W;
    localparam int RAD_W = circ_pkg::RAD_W;
    localparam int SQ_W  = circ_pkg::SQ_W;
    localparam int DW    = CW + 1;          // relative coordinate
    localparam int PW    = 2 * CW + 2;      // first products
    localparam int SW    = 2 * CW + 3;      // sums of products
    localparam int DVW   = 2 * CW + 4;      // divisor, signed
    localparam int MW    = 3 * CW + 4;      // second products
    localparam int NW0   = 3 * CW + 6;      // numerator before scaling
    localparam int QW    = NW0 + FB;        // scaled numerator and quotient
    localparam int EXW   = QW + 2;          // common compare width
    localparam int AXW   = CW + FB;         // scaled A coordinate
    localparam int TAG1  = 2 * CW + 4;
    localparam int TAG2  = 2 * OUT_W + 4;
    localparam logic signed [EXW-1:0] MAXV = EXW'(64'sh7FFF_FFFF);
    localparam logic signed [EXW-1:0] MINV = EXW'(-64'sh8000_0000);

    // saturate to 32 bits; msb of the result flags overflow
    function automatic logic [OUT_W:0] sat32(input logic signed [EXW-1:0] v);
        logic [OUT_W:0] r;
        if (v > MAXV)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < MINV)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[OUT_W-1:0]};
        return r;
    endfunction

    // configuration register
    logic [circ_pkg::TOL_W-1:0] tol_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    // pipeline advances unless the skid word is held
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic adv;
    assign adv      = ~skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // valid chain for the front and back stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic dv_out, sv_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= dv_out;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    // stage 1: coordinates relative to A
    logic signed [CW-1:0] ax1_reg, ay1_reg;
    logic signed [DW-1:0] bxr_reg, byr_reg, cxr_reg, cyr_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg <= point_a_x;
            ay1_reg <= point_a_y;
            bxr_reg <= DW'(point_b_x) - DW'(point_a_x);
            byr_reg <= DW'(point_b_y) - DW'(point_a_y);
            cxr_reg <= DW'(point_c_x) - DW'(point_a_x);
            cyr_reg <= DW'(point_c_y) - DW'(point_a_y);
        end
    end

    // stage 2: cross products and squares
    logic signed [CW-1:0] ax2_reg, ay2_reg;
    logic signed [DW-1:0] bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [PW-1:0] pbc_reg, pyx_reg, sbx_reg, sby_reg, scx_reg, scy_reg;
    logic                 allz2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            bx2_reg   <= bxr_reg;
            by2_reg   <= byr_reg;
            cx2_reg   <= cxr_reg;
            cy2_reg   <= cyr_reg;
            pbc_reg   <= PW'(bxr_reg) * PW'(cyr_reg);
            pyx_reg   <= PW'(byr_reg) * PW'(cxr_reg);
            sbx_reg   <= PW'(bxr_reg) * PW'(bxr_reg);
            sby_reg   <= PW'(byr_reg) * PW'(byr_reg);
            scx_reg   <= PW'(cxr_reg) * PW'(cxr_reg);
            scy_reg   <= PW'(cyr_reg) * PW'(cyr_reg);
            allz2_reg <= (bxr_reg == '0) && (byr_reg == '0) &&
                         (cxr_reg == '0) && (cyr_reg == '0);
        end
    end

    // stage 3: divisor and squared lengths
    logic signed [CW-1:0]  ax3_reg, ay3_reg;
    logic signed [DW-1:0]  bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [DVW-1:0] div3_reg;
    logic signed [SW-1:0]  bb_reg, cc_reg;
    logic                  allz3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            div3_reg  <= DVW'(SW'(pbc_reg) - SW'(pyx_reg)) <<< 1;
            bb_reg    <= SW'(sbx_reg) + SW'(sby_reg);
            cc_reg    <= SW'(scx_reg) + SW'(scy_reg);
            allz3_reg <= allz2_reg;
        end
    end

    // stage 4: numerator products and the collinear test
    logic [DVW-1:0]        dmag3;
    assign dmag3 = div3_reg[DVW-1] ? (~div3_reg + DVW'(1)) : div3_reg;

    logic signed [CW-1:0]  ax4_reg, ay4_reg;
    logic signed [DVW-1:0] div4_reg;
    logic signed [MW-1:0]  m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic                  allz4_reg, coll4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            div4_reg  <= div3_reg;
            m1_reg    <= MW'(bb_reg) * MW'(cy3_reg);
            m2_reg    <= MW'(cc_reg) * MW'(by3_reg);
            m3_reg    <= MW'(cc_reg) * MW'(bx3_reg);
            m4_reg    <= MW'(bb_reg) * MW'(cx3_reg);
            m5_reg    <= MW'(ax3_reg) * MW'(div3_reg);
            m6_reg    <= MW'(ay3_reg) * MW'(div3_reg);
            allz4_reg <= allz3_reg;
            coll4_reg <= (dmag3 <= DVW'(tol_reg));
        end
    end

    // stage 5: scaled numerators
    logic signed [CW-1:0]  ax5_reg, ay5_reg;
    logic signed [DVW-1:0] div5_reg;
    logic signed [QW-1:0]  nx5_reg, ny5_reg;
    logic                  allz5_reg, coll5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            div5_reg  <= div4_reg;
            nx5_reg   <= QW'(NW0'(m5_reg) + NW0'(m1_reg) - NW0'(m2_reg)) <<< FB;
            ny5_reg   <= QW'(NW0'(m6_reg) + NW0'(m3_reg) - NW0'(m4_reg)) <<< FB;
            allz5_reg <= allz4_reg;
            coll5_reg <= coll4_reg;
        end
    end

    // stage 6: magnitudes and quotient signs
    logic [QW-1:0]   nxm6_reg, nym6_reg;
    logic [DVW-1:0]  dm6_reg;
    logic [TAG1-1:0] tag6_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nxm6_reg <= nx5_reg[QW-1] ? (~nx5_reg + QW'(1)) : nx5_reg;
            nym6_reg <= ny5_reg[QW-1] ? (~ny5_reg + QW'(1)) : ny5_reg;
            dm6_reg  <= div5_reg[DVW-1] ? (~div5_reg + DVW'(1)) : div5_reg;
            tag6_reg <= {ax5_reg, ay5_reg, coll5_reg, allz5_reg,
                         nx5_reg[QW-1] ^ div5_reg[DVW-1],
                         ny5_reg[QW-1] ^ div5_reg[DVW-1]};
        end
    end

    // divider
    logic [QW-1:0]   qmx, qmy;
    logic [TAG1-1:0] dtag;
    circ_div #(
        .QW    (QW),
        .DM    (DVW),
        .TAG_W (TAG1)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (v6_reg),
        .num_x   (nxm6_reg),
        .num_y   (nym6_reg),
        .den     (dm6_reg),
        .tag_in  (tag6_reg),
        .out_v   (dv_out),
        .quo_x   (qmx),
        .quo_y   (qmy),
        .tag_out (dtag)
    );

    // stage 7: signed quotients and scaled A coordinates
    logic signed [QW:0]    qx7_reg, qy7_reg;
    logic signed [AXW-1:0] axs7_reg, ays7_reg;
    logic                  coll7_reg, allz7_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx7_reg   <= dtag[1] ? $signed(-{1'b0, qmx}) : $signed({1'b0, qmx});
            qy7_reg   <= dtag[0] ? $signed(-{1'b0, qmy}) : $signed({1'b0, qmy});
            axs7_reg  <= AXW'($signed(dtag[TAG1-1 -: CW])) <<< FB;
            ays7_reg  <= AXW'($signed(dtag[TAG1-1-CW -: CW])) <<< FB;
            coll7_reg <= dtag[3];
            allz7_reg <= dtag[2];
        end
    end

    // stage 8: center select with saturation, offsets from A
    logic [OUT_W:0] sqx, sqy, sax, say;
    logic signed [OUT_W-1:0] cx8_next, cy8_next;
    logic                    ovc8_next;
    always_comb
    begin
        sqx = sat32(EXW'(qx7_reg));
        sqy = sat32(EXW'(qy7_reg));
        sax = sat32(EXW'(axs7_reg));
        say = sat32(EXW'(ays7_reg));
        if (coll7_reg && allz7_reg)
        begin
            cx8_next  = sax[OUT_W-1:0];
            cy8_next  = say[OUT_W-1:0];
            ovc8_next = sax[OUT_W] | say[OUT_W];
        end
        else if (coll7_reg)
        begin
            cx8_next  = '0;
            cy8_next  = '0;
            ovc8_next = 1'b0;
        end
        else
        begin
            cx8_next  = sqx[OUT_W-1:0];
            cy8_next  = sqy[OUT_W-1:0];
            ovc8_next = sqx[OUT_W] | sqy[OUT_W];
        end
    end

    logic signed [EXW-1:0]   dx8_reg, dy8_reg;
    logic signed [OUT_W-1:0] cx8_reg, cy8_reg;
    logic                    ovc8_reg, coll8_reg, allz8_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx8_reg   <= EXW'(qx7_reg) - EXW'(axs7_reg);
            dy8_reg   <= EXW'(qy7_reg) - EXW'(ays7_reg);
            cx8_reg   <= cx8_next;
            cy8_reg   <= cy8_next;
            ovc8_reg  <= ovc8_next;
            coll8_reg <= coll7_reg;
            allz8_reg <= allz7_reg;
        end
    end

    // stage 9: offset magnitudes and range check
    logic [EXW-1:0] ex9_next, ey9_next;
    assign ex9_next = dx8_reg[EXW-1] ? (~dx8_reg + EXW'(1)) : dx8_reg;
    assign ey9_next = dy8_reg[EXW-1] ? (~dy8_reg + EXW'(1)) : dy8_reg;

    logic [RAD_W-1:0]        ex9_reg, ey9_reg;
    logic signed [OUT_W-1:0] cx9_reg, cy9_reg;
    logic                    ovc9_reg, ovr9_reg, coll9_reg, allz9_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex9_reg   <= ex9_next[RAD_W-1:0];
            ey9_reg   <= ey9_next[RAD_W-1:0];
            ovr9_reg  <= ((ex9_next >> RAD_W) != '0) || ((ey9_next >> RAD_W) != '0);
            cx9_reg   <= cx8_reg;
            cy9_reg   <= cy8_reg;
            ovc9_reg  <= ovc8_reg;
            coll9_reg <= coll8_reg;
            allz9_reg <= allz8_reg;
        end
    end

    // stage 10: squares
    logic [SQ_W-1:0]         sx10_reg, sy10_reg;
    logic signed [OUT_W-1:0] cx10_reg, cy10_reg;
    logic                    ovc10_reg, ovr10_reg, coll10_reg, allz10_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx10_reg   <= SQ_W'(ex9_reg) * SQ_W'(ex9_reg);
            sy10_reg   <= SQ_W'(ey9_reg) * SQ_W'(ey9_reg);
            cx10_reg   <= cx9_reg;
            cy10_reg   <= cy9_reg;
            ovc10_reg  <= ovc9_reg;
            ovr10_reg  <= ovr9_reg;
            coll10_reg <= coll9_reg;
            allz10_reg <= allz9_reg;
        end
    end

    // stage 11: squared radius
    logic [SQ_W:0]    sq11_next;
    assign sq11_next = {1'b0, sx10_reg} + {1'b0, sy10_reg};

    logic [SQ_W-1:0]  sq11_reg;
    logic [TAG2-1:0]  tag11_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq11_reg  <= sq11_next[SQ_W-1:0];
            tag11_reg <= {cx10_reg, cy10_reg, coll10_reg, allz10_reg, ovc10_reg,
                          ovr10_reg | sq11_next[SQ_W]};
        end
    end

    // square root
    logic [RAD_W-1:0] root;
    logic [TAG2-1:0]  stag;
    circ_sqrt #(
        .TAG_W (TAG2)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (v11_reg),
        .operand (sq11_reg),
        .tag_in  (tag11_reg),
        .out_v   (sv_out),
        .root    (root),
        .tag_out (stag)
    );

    // final word assembly
    logic             f_coll, f_allz, f_ovc, f_ovr;
    logic [RAD_W-1:0] f_rad;
    circ_pkg::status_t f_st;
    assign f_coll = stag[3];
    assign f_allz = stag[2];
    assign f_ovc  = stag[1];
    assign f_ovr  = stag[0];

    always_comb
    begin
        if (f_coll && f_allz)
        begin
            f_rad = f_ovc ? '1 : '0;
            f_st  = f_ovc ? circ_pkg::ST_SAT : circ_pkg::ST_POINT;
        end
        else if (f_coll)
        begin
            f_rad = '0;
            f_st  = circ_pkg::ST_COLLINEAR;
        end
        else
        begin
            f_rad = f_ovr ? '1 : root;
            f_st  = (f_ovc || f_ovr) ? circ_pkg::ST_SAT : circ_pkg::ST_OK;
        end
    end

    // output register with one skid word
    logic                    out_take;
    logic signed [OUT_W-1:0] ocx_reg, ocy_reg, kcx_reg, kcy_reg;
    logic [RAD_W-1:0]        orad_reg, krad_reg;
    circ_pkg::status_t       ost_reg, kst_reg;
    assign out_take = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (adv)
        begin
            if (out_take)
                out_valid_next = sv_out;
            else if (sv_out)
                skid_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (out_take)
            begin
                ocx_reg  <= stag[TAG2-1 -: OUT_W];
                ocy_reg  <= stag[TAG2-1-OUT_W -: OUT_W];
                orad_reg <= f_rad;
                ost_reg  <= f_st;
            end
            else
            begin
                kcx_reg  <= stag[TAG2-1 -: OUT_W];
                kcy_reg  <= stag[TAG2-1-OUT_W -: OUT_W];
                krad_reg <= f_rad;
                kst_reg  <= f_st;
            end
        end
        else if (out_take)
        begin
            ocx_reg  <= kcx_reg;
            ocy_reg  <= kcy_reg;
            orad_reg <= krad_reg;
            ost_reg  <= kst_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign center_x  = ocx_reg;
    assign center_y  = ocy_reg;
    assign radius    = orad_reg;
    assign status    = ost_reg;

`ifndef SYNTHESIS
    // a skid word exists only behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // skid fills only when the output word was held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled while output was free");

    // collinear words carry a zero circle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == circ_pkg::ST_COLLINEAR) |->
        (center_x == '0 && center_y == '0 && radius == '0))
        else $error("collinear word with nonzero circle");

    // point circles have zero radius
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == circ_pkg::ST_POINT) |-> (radius == '0))
        else $error("point circle with nonzero radius");
`endif

endmodule

// File: tb/sv/circumcircle_from_three_points_test.sv
// Testbench for circumcircle_from_three_points: drives triangles, predicts center,
// radius and status in fixed point, and checks every result word in order.
// Depends on circ_pkg and the circumcircle_from_three_points RTL.
`timescale 1ns / 1ps

module circumcircle_from_three_points_test;

    typedef struct {
        logic signed [15:0] ax, ay, bx, by, cx, cy;
    } triangle_t;

    typedef struct {
        logic signed [31:0] cx, cy;
        logic [31:0]        rad;
        circ_pkg::status_t  st;
    } circle_t;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] point_a_x = '0, point_a_y = '0, point_b_x = '0;
    logic signed [15:0] point_b_y = '0, point_c_x = '0, point_c_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] center_x, center_y;
    logic [31:0] radius;
    logic [1:0] status;

    circle_t     pending_circles[$];
    logic [15:0] tol_model = '0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_cycles = 0;

    circumcircle_from_three_points u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_a_x(point_a_x), .point_a_y(point_a_y),
        .point_b_x(point_b_x), .point_b_y(point_b_y),
        .point_c_x(point_c_x), .point_c_y(point_c_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .center_x(center_x), .center_y(center_y),
        .radius(radius), .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // saturate to int32, flag overflow
    function automatic logic [31:0] clamp32(longint v, inout logic ovf);
        if (v > 64'sh7FFFFFFF)
        begin
            ovf = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sh80000000)
        begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] floor_sqrt(logic [63:0] x);
        logic [31:0]  res;
        logic [31:0]  trial;
        logic [127:0] prod;
        res = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = res | (32'd1 << i);
            prod = 128'(trial) * 128'(trial);
            if (prod <= 128'(x))
                res = trial;
        end
        return res;
    endfunction

    // expected circle for one triangle at the given tolerance
    function automatic circle_t circle_of(triangle_t t, logic [15:0] tol);
        longint ax, ay, bxr, byr, cxr, cyr, dv, bb, cc, nx, ny, qx, qy, ex, ey;
        logic [127:0] sq;
        logic ovf;
        circle_t c;
        ax = t.ax; ay = t.ay;
        bxr = longint'(t.bx) - ax; byr = longint'(t.by) - ay;
        cxr = longint'(t.cx) - ax; cyr = longint'(t.cy) - ay;
        dv = 2 * (bxr * cyr - byr * cxr);
        ovf = 1'b0;
        if ((dv < 0 ? -dv : dv) <= longint'(tol))
        begin
            if (bxr == 0 && byr == 0 && cxr == 0 && cyr == 0)
            begin
                c.cx = clamp32(ax * 256, ovf);
                c.cy = clamp32(ay * 256, ovf);
                c.rad = ovf ? 32'hFFFFFFFF : 32'd0;
                c.st = ovf ? circ_pkg::ST_SAT : circ_pkg::ST_POINT;
            end
            else
            begin
                c.cx = '0; c.cy = '0; c.rad = '0;
                c.st = circ_pkg::ST_COLLINEAR;
            end
            return c;
        end
        bb = bxr * bxr + byr * byr;
        cc = cxr * cxr + cyr * cyr;
        nx = (ax * dv + bb * cyr - cc * byr) * 256;
        ny = (ay * dv + cc * bxr - bb * cxr) * 256;
        qx = nx / dv;
        qy = ny / dv;
        c.cx = clamp32(qx, ovf);
        c.cy = clamp32(qy, ovf);
        ex = qx - ax * 256; if (ex < 0) ex = -ex;
        ey = qy - ay * 256; if (ey < 0) ey = -ey;
        if ((ex >>> 32) != 0 || (ey >>> 32) != 0)
        begin
            c.rad = 32'hFFFFFFFF;
            ovf = 1'b1;
        end
        else
        begin
            sq = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey);
            if (sq[127:64] != 0)
            begin
                c.rad = 32'hFFFFFFFF;
                ovf = 1'b1;
            end
            else
                c.rad = floor_sqrt(sq[63:0]);
        end
        c.st = ovf ? circ_pkg::ST_SAT : circ_pkg::ST_OK;
        return c;
    endfunction

    // record expectation for each accepted word
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_circles.push_back(circle_of('{point_a_x, point_a_y, point_b_x,
                point_b_y, point_c_x, point_c_y}, tol_model));
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        circle_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_circles.size() == 0)
            begin
                $error("result word with no expectation");
                errors++;
            end
            else
            begin
                want = pending_circles.pop_front();
                if (center_x !== want.cx)
                begin
                    $error("center_x expected %0d got %0d", want.cx, center_x);
                    errors++;
                end
                if (center_y !== want.cy)
                begin
                    $error("center_y expected %0d got %0d", want.cy, center_y);
                    errors++;
                end
                if (radius !== want.rad)
                begin
                    $error("radius expected %0d got %0d", want.rad, radius);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $error("status expected %0d got %0d", want.st, status);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall pattern, quiet stretches, and requested hold-offs
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 80);
            end
            left--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else if (pending_circles.size() != 0 || in_valid)
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("circumcircle_from_three_points: mismatch");
                $finish;
            end
        end
    end

    // send one word; leaves valid high so bursts run back to back
    task automatic send_triangle(triangle_t t);
        point_a_x <= t.ax; point_a_y <= t.ay;
        point_b_x <= t.bx; point_b_y <= t.by;
        point_c_x <= t.cx; point_c_y <= t.cy;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        pause_sender(1);
        while (pending_circles.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        tol_model = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord(int span);
        if (span == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        int span;
        int kind;
        kind = $urandom_range(0, 9);
        span = (kind < 4) ? 0 : (kind < 7) ? 40 : 3;
        t = '{pick_coord(span), pick_coord(span), pick_coord(span),
              pick_coord(span), pick_coord(span), pick_coord(span)};
        if (kind == 9)
        begin
            // collinear along a random step, or all points equal
            t.bx = t.ax + t.cx[3:0];
            t.by = t.ay + t.cy[3:0];
            t.cx = t.ax + {t.cx[3:0], 1'b0};
            t.cy = t.ay + {t.cy[3:0], 1'b0};
        end
        return t;
    endfunction

    task automatic send_random(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && n > 0; i++, n--)
                send_triangle(random_triangle());
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    task automatic test_directed();
        send_triangle('{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd0, 16'sd3});
        send_triangle('{16'sd1, 16'sd1, 16'sd5, 16'sd1, 16'sd1, 16'sd4});
        send_triangle('{-16'sd7, 16'sd2, 16'sd3, -16'sd5, 16'sd9, 16'sd11});
        // all points equal at each extreme: point circle
        send_triangle('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_triangle('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_triangle('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        // collinear, including two equal points
        send_triangle('{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd2});
        send_triangle('{16'h8000, 16'h8000, 16'sd0, 16'sd0, 16'h7FFF, 16'h7FFF});
        send_triangle('{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd9, 16'sd5});
        // nearly collinear, far apart: center does not fit
        send_triangle('{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFE});
        send_triangle('{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFE, 16'h8000});
        // widest regular triangles
        send_triangle('{16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
        send_triangle('{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
        send_triangle('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA});
    endtask

    task automatic test_tolerance_sweep();
        triangle_t t;
        // tiny divisors around the threshold
        write_tolerance(16'd4);
        send_triangle('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
        send_triangle('{16'sd0, 16'sd0, 16'sd2, 16'sd0, 16'sd1, 16'sd1});
        send_triangle('{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3});
        send_random(60);
        write_tolerance(16'hFFFF);
        send_triangle('{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd100});
        send_triangle('{16'sd0, 16'sd0, 16'sd200, 16'sd0, 16'sd0, 16'sd200});
        send_random(60);
        write_tolerance(16'($urandom_range(1, 16'hFFFE)));
        send_random(40);
        write_tolerance(16'd0);
        t = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        send_triangle(t);
    endtask

    // long receiver hold-off while the sender keeps offering words
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 150; i++)
            send_triangle(random_triangle());
    endtask

    task automatic test_random();
        send_random(70);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_tolerance_sweep();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending_circles.size() == 0)
            $display("circumcircle_from_three_points: match");
        else
            $display("circumcircle_from_three_points: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/circ_pkg.sv
rtl/circ_div.sv
rtl/circ_sqrt.sv
rtl/circumcircle_from_three_points.sv
tb/sv/circumcircle_from_three_points_test.sv
